// File: rtl/edge_log_compactor_core_assert.svh
// Assertion macros for the edge log compactor core.
// Used by edge_log_compactor_core; expects clk and rst_n in scope.
`ifndef EDGE_LOG_COMPACTOR_CORE_ASSERT_SVH
`define EDGE_LOG_COMPACTOR_CORE_ASSERT_SVH

// same-cycle implication
`define ELC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("elc assertion failed");

// next-cycle implication
`define ELC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("elc assertion failed");

`endif

// File: rtl/elc_pkg.sv
// Package for the edge log compactor: transaction structs, codes, FSM state.
// No dependencies.
package elc_pkg;

    localparam int DEST_W   = 12;
    localparam int WEIGHT_W = 32;
    localparam int LENGTH_W = 7;

    localparam logic       CMD_APPEND  = 1'b0;
    localparam logic       CMD_COMPACT = 1'b1;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [1:0] ST_APPENDED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ENTRY    = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                command;
        logic [DEST_W-1:0]   dest;
        logic [WEIGHT_W-1:0] weight;
        logic [1:0]          kind;
    } elc_cmd_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [DEST_W-1:0]   entry_dest;
        logic [WEIGHT_W-1:0] entry_weight;
        logic                last;
        logic [LENGTH_W-1:0] length;
    } elc_result_t;

    typedef struct packed {
        logic [DEST_W-1:0]   dest;
        logic [WEIGHT_W-1:0] weight;
    } elc_entry_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_W_RD,
        S_W_SEEN,
        S_W_DEC,
        S_C_RD,
        S_C_WR,
        S_E_RD,
        S_E_OUT
    } elc_state_t;

endpackage

// File: rtl/edge_log_compactor_core.sv
// Edge log compactor core: one vertex's edge log with append and compaction.
// Depends on elc_pkg and edge_log_compactor_core_assert.svh.
//
// An append's result is registered and shows on the next cycle, and busy stays
// low. A compaction raises busy until its last result: after reset a clearing
// pass first sweeps all 2^VERTEX_BITS entries of the seen bitmap. A compaction
// walks the log from newest to oldest entry (log read, bitmap read, decide),
// then clears the marks of the entries past the snapshot region (log read,
// bitmap write), then emits each kept entry (read, output). The copy-forward
// case skips the walk and clear. Results come one per strobe and cannot stall.
module edge_log_compactor_core #(
    parameter int LOG_DEPTH   = 64,
    parameter int VERTEX_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  elc_pkg::elc_cmd_t    cmd,
    output logic                 valid,
    output elc_pkg::elc_result_t result
);
    import elc_pkg::*;

    localparam int LW = $clog2(LOG_DEPTH + 1);
    localparam int AW = $clog2(LOG_DEPTH);
    localparam int SEEN_DEPTH = 1 << VERTEX_BITS;
    localparam logic [DEST_W-1:0] DMASK =
        (VERTEX_BITS >= DEST_W) ? {DEST_W{1'b1}} : DEST_W'((1 << VERTEX_BITS) - 1);

    elc_state_t state_reg, state_next;
    logic [LW-1:0] len_reg, len_next, snap_reg, snap_next;
    logic [7:0]    deg_reg, deg_next;
    logic [LW-1:0] p_reg, p_next, num_reg, num_next, ptr_reg, ptr_next;
    logic          copy_reg, copy_next;
    logic [VERTEX_BITS-1:0] init_reg, init_next;
    logic          valid_reg, valid_next;
    elc_result_t   res_reg, res_next;

    elc_entry_t log_mem [LOG_DEPTH];
    elc_entry_t tmp_mem [LOG_DEPTH];
    logic       seen_mem [SEEN_DEPTH];

    logic       log_we, log_re, tmp_we, tmp_re, seen_we, seen_re, seen_wd;
    logic [AW-1:0] log_wa, log_ra, tmp_wa, tmp_ra;
    elc_entry_t log_wd, log_rd, tmp_wd, tmp_rd;
    logic [VERTEX_BITS-1:0] seen_wa, seen_ra;
    logic       seen_rd;

    logic [LW-1:0] snap_eff, p_dec;
    logic          accept, deg_match, keep;
    elc_entry_t    emit_ent;

    assign accept    = start && (state_reg == S_IDLE);
    assign snap_eff  = (snap_reg > len_reg) ? len_reg : snap_reg;
    assign p_dec     = p_reg - LW'(1);
    assign deg_match = !deg_reg[7] && (deg_reg == 8'(len_reg));
    assign keep      = !seen_rd && (log_rd.weight[WEIGHT_W-2:0] != '0);
    assign emit_ent  = copy_reg ? log_rd : tmp_rd;
    assign busy      = (state_reg != S_IDLE);
    assign valid     = valid_reg;
    assign result    = res_reg;

    always_ff @(posedge clk)
    begin
        if (log_we)
        begin
            log_mem[log_wa] <= log_wd;
        end
        if (log_re)
        begin
            log_rd <= log_mem[log_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tmp_we)
        begin
            tmp_mem[tmp_wa] <= tmp_wd;
        end
        if (tmp_re)
        begin
            tmp_rd <= tmp_mem[tmp_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_wa] <= seen_wd;
        end
        if (seen_re)
        begin
            seen_rd <= seen_mem[seen_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            len_reg   <= '0;
            snap_reg  <= '0;
            deg_reg   <= '0;
            p_reg     <= '0;
            num_reg   <= '0;
            ptr_reg   <= '0;
            copy_reg  <= 1'b0;
            init_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            snap_reg  <= snap_next;
            deg_reg   <= deg_next;
            p_reg     <= p_next;
            num_reg   <= num_next;
            ptr_reg   <= ptr_next;
            copy_reg  <= copy_next;
            init_reg  <= init_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (init_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && cmd.command == CMD_COMPACT)
                begin
                    state_next = deg_match ? S_E_RD : S_W_RD;
                end
            end
            S_W_RD:   state_next = (p_reg == '0) ? S_C_RD : S_W_SEEN;
            S_W_SEEN: state_next = S_W_DEC;
            S_W_DEC:  state_next = S_W_RD;
            S_C_RD:   state_next = (ptr_reg >= len_reg) ? S_E_RD : S_C_WR;
            S_C_WR:   state_next = S_C_RD;
            S_E_RD:   state_next = (ptr_reg >= num_reg) ? S_IDLE : S_E_OUT;
            S_E_OUT:  state_next = S_E_RD;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        len_next   = len_reg;
        snap_next  = snap_reg;
        deg_next   = deg_reg;
        p_next     = p_reg;
        num_next   = num_reg;
        ptr_next   = ptr_reg;
        copy_next  = copy_reg;
        init_next  = init_reg;
        valid_next = 1'b0;
        res_next   = '0;
        log_we = 1'b0; log_wa = '0; log_wd = '0; log_re = 1'b0; log_ra = '0;
        tmp_we = 1'b0; tmp_wa = '0; tmp_wd = '0; tmp_re = 1'b0; tmp_ra = '0;
        seen_we = 1'b0; seen_wa = '0; seen_wd = 1'b0; seen_re = 1'b0; seen_ra = '0;
        unique case (state_reg)
            S_INIT:
            begin
                seen_we   = 1'b1;
                seen_wa   = init_reg;
                init_next = init_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept && cmd.command == CMD_APPEND)
                begin
                    valid_next    = 1'b1;
                    res_next.last = 1'b1;
                    if (len_reg >= LW'(LOG_DEPTH))
                    begin
                        res_next.status = ST_FULL;
                        res_next.length = LENGTH_W'(len_reg);
                    end
                    else
                    begin
                        log_we        = 1'b1;
                        log_wa        = AW'(len_reg);
                        log_wd.dest   = cmd.dest & DMASK;
                        log_wd.weight = (cmd.kind == KIND_DELETE) ? '0 : cmd.weight;
                        len_next      = len_reg + LW'(1);
                        if (cmd.kind == KIND_INSERT)
                        begin
                            deg_next = deg_reg + 8'd1;
                        end
                        else if (cmd.kind == KIND_DELETE)
                        begin
                            deg_next = deg_reg - 8'd1;
                        end
                        res_next.status = ST_APPENDED;
                        res_next.length = LENGTH_W'(len_reg + LW'(1));
                    end
                end
                else if (accept)
                begin
                    copy_next = deg_match;
                    p_next    = len_reg;
                    num_next  = deg_match ? len_reg : '0;
                    ptr_next  = deg_match ? '0 : snap_eff;
                end
            end
            S_W_RD:
            begin
                if (p_reg != '0)
                begin
                    log_re = 1'b1;
                    log_ra = AW'(p_dec);
                end
            end
            S_W_SEEN:
            begin
                seen_re = 1'b1;
                seen_ra = VERTEX_BITS'(log_rd.dest);
            end
            S_W_DEC:
            begin
                if (keep)
                begin
                    tmp_we   = 1'b1;
                    tmp_wa   = AW'(num_reg);
                    tmp_wd   = log_rd;
                    num_next = num_reg + LW'(1);
                end
                if (!seen_rd && p_dec >= snap_eff)
                begin
                    seen_we = 1'b1;
                    seen_wa = VERTEX_BITS'(log_rd.dest);
                    seen_wd = 1'b1;
                end
                p_next = p_dec;
            end
            S_C_RD:
            begin
                if (ptr_reg < len_reg)
                begin
                    log_re = 1'b1;
                    log_ra = AW'(ptr_reg);
                end
                else
                begin
                    ptr_next = '0;
                end
            end
            S_C_WR:
            begin
                seen_we  = 1'b1;
                seen_wa  = VERTEX_BITS'(log_rd.dest);
                ptr_next = ptr_reg + LW'(1);
            end
            S_E_RD:
            begin
                if (ptr_reg >= num_reg)
                begin
                    len_next  = num_reg;
                    snap_next = num_reg;
                    deg_next  = 8'(num_reg);
                    if (num_reg == '0)
                    begin
                        valid_next      = 1'b1;
                        res_next.status = ST_EMPTY;
                        res_next.last   = 1'b1;
                    end
                end
                else if (copy_reg)
                begin
                    log_re = 1'b1;
                    log_ra = AW'(ptr_reg);
                end
                else
                begin
                    tmp_re = 1'b1;
                    tmp_ra = AW'(ptr_reg);
                end
            end
            S_E_OUT:
            begin
                valid_next            = 1'b1;
                res_next.status       = ST_ENTRY;
                res_next.entry_dest   = emit_ent.dest;
                res_next.entry_weight = emit_ent.weight;
                res_next.last         = (ptr_reg + LW'(1) == num_reg);
                res_next.length       = LENGTH_W'(num_reg);
                if (!copy_reg)
                begin
                    log_we = 1'b1;
                    log_wa = AW'(ptr_reg);
                    log_wd = tmp_rd;
                end
                ptr_next = ptr_reg + LW'(1);
            end
            default:
            begin
            end
        endcase
    end

`include "edge_log_compactor_core_assert.svh"

    `ELC_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LW'(LOG_DEPTH))
    `ELC_ASSERT_NOW(a_walk_num, state_reg == S_W_DEC, num_reg <= len_reg)
    `ELC_ASSERT_NEXT(a_append_result, start && !busy && cmd.command == CMD_APPEND, valid && result.last)
    `ELC_ASSERT_NEXT(a_last_frees, valid && result.last && result.status == ST_ENTRY, !busy)

endmodule
